// File: rtl/mi3_pkg.sv
// Shared constants for the 3x3 fixed-point matrix inverter.
package mi3_pkg;

	localparam int ENTRY_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int THRESH_WIDTH  = 31;
	localparam int N_ENTRIES     = 9;

	// Cofactor i = m[a]*m[b] - m[c]*m[d], row-major entry indexes
	localparam int COF_IDX [9][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

endpackage

// File: rtl/mi3_cofactor.sv
// Two-stage pipeline forming the nine exact 2x2 cofactors (adjugate entries).
module mi3_cofactor #(
	parameter int E = mi3_pkg::ENTRY_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [mi3_pkg::N_ENTRIES-1:0][E-1:0]   m_in,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [mi3_pkg::N_ENTRIES-1:0][E-1:0]   m_out,
	output logic [mi3_pkg::N_ENTRIES-1:0][2*E:0]   adj_out
);

	localparam int N = mi3_pkg::N_ENTRIES;

	logic [N-1:0][2*E-1:0] prod_p_s1;
	logic [N-1:0][2*E-1:0] prod_s_s1;
	logic [N-1:0][E-1:0]   m_s1;
	logic                  vld_s1;
	logic [N-1:0][2*E:0]   adj_s2;
	logic [N-1:0][E-1:0]   m_s2;
	logic                  vld_s2;
	logic                  en1, en2;

	assign en2      = !vld_s2 || out_ready;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			m_s1 <= m_in;
			for (int i = 0; i < N; i++) begin
				prod_p_s1[i] <= $signed(m_in[mi3_pkg::COF_IDX[i][0]])
					* $signed(m_in[mi3_pkg::COF_IDX[i][1]]);
				prod_s_s1[i] <= $signed(m_in[mi3_pkg::COF_IDX[i][2]])
					* $signed(m_in[mi3_pkg::COF_IDX[i][3]]);
			end
		end
		if (en2) begin
			m_s2 <= m_s1;
			for (int i = 0; i < N; i++)
				adj_s2[i] <= {prod_p_s1[i][2*E-1], prod_p_s1[i]}
					- {prod_s_s1[i][2*E-1], prod_s_s1[i]};
		end
	end

	assign out_valid = vld_s2;
	assign m_out     = m_s2;
	assign adj_out   = adj_s2;

endmodule

// File: rtl/mi3_det.sv
// Four-stage pipeline: determinant, magnitudes, signs, threshold and range checks.
module mi3_det #(
	parameter int E  = mi3_pkg::ENTRY_WIDTH,
	parameter int F  = mi3_pkg::FRACTION_BITS,
	parameter int NW = 2 * E + 1 + 2 * F,
	parameter int DW = 3 * E + 3
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [mi3_pkg::THRESH_WIDTH-1:0]       thr,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [mi3_pkg::N_ENTRIES-1:0][E-1:0]   m_in,
	input  logic [mi3_pkg::N_ENTRIES-1:0][2*E:0]   adj_in,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [mi3_pkg::N_ENTRIES-1:0][E-1:0]   m_out,
	output logic [mi3_pkg::N_ENTRIES-1:0][NW-1:0]  num_out,
	output logic [DW-1:0]                          den_out,
	output logic [mi3_pkg::N_ENTRIES-1:0]          neg_out,
	output logic [mi3_pkg::N_ENTRIES-1:0]          ovf_out,
	output logic                                   inv_out
);

	localparam int N   = mi3_pkg::N_ENTRIES;
	localparam int AW  = 2 * E + 1;
	localparam int THW = mi3_pkg::THRESH_WIDTH + 2 * F;
	localparam int TW  = (DW > THW) ? DW : THW;
	localparam int CW  = (NW > DW + E) ? NW : DW + E;

	logic [2:0][AW-1:0]   pl_s3, ph_s3;
	logic [N-1:0][AW-1:0] adj_s3, adj_s4;
	logic [N-1:0][E-1:0]  m_s3, m_s4, m_s5, m_s6;
	logic [DW-1:0]        det_s4;
	logic [DW-1:0]        den_s5, den_s6;
	logic [N-1:0][AW-1:0] mag_s5;
	logic [N-1:0]         neg_s5, neg_s6, ovf_s6;
	logic [N-1:0][NW-1:0] num_s6;
	logic                 inv_s6;
	logic [3:0]           vld;
	logic [4:0]           en;
	logic [DW-1:0]        det_sum;
	logic                 inv_c;
	logic [N-1:0]         ovf_c;

	assign en[4] = out_ready;
	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_en
			assign en[g] = !vld[g] || en[g+1];
		end
	endgenerate
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[0]) vld[0] <= in_valid;
			for (int k = 1; k < 4; k++)
				if (en[k]) vld[k] <= vld[k-1];
		end
	end

	// split each row-one cofactor so no product exceeds entry by entry-plus-one bits
	always_comb begin
		det_sum = '0;
		for (int k = 0; k < 3; k++)
			det_sum = det_sum
				+ {{2{ph_s3[k][AW-1]}}, ph_s3[k], {E{1'b0}}}
				+ {{(E+2){pl_s3[k][AW-1]}}, pl_s3[k]};
	end

	always_comb begin
		inv_c = TW'(den_s5) > TW'({thr, {(2*F){1'b0}}});
		for (int i = 0; i < N; i++)
			ovf_c[i] = CW'({mag_s5[i], {(2*F){1'b0}}}) >= CW'({den_s5, {E{1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			m_s3   <= m_in;
			adj_s3 <= adj_in;
			for (int k = 0; k < 3; k++) begin
				pl_s3[k] <= $signed(m_in[k]) * $signed({1'b0, adj_in[3*k][E-1:0]});
				ph_s3[k] <= $signed(m_in[k]) * $signed(adj_in[3*k][2*E:E]);
			end
		end
		if (en[1]) begin
			m_s4   <= m_s3;
			adj_s4 <= adj_s3;
			det_s4 <= det_sum;
		end
		if (en[2]) begin
			m_s5   <= m_s4;
			den_s5 <= det_s4[DW-1] ? (DW'(0) - det_s4) : det_s4;
			for (int i = 0; i < N; i++) begin
				mag_s5[i] <= adj_s4[i][AW-1] ? (AW'(0) - adj_s4[i]) : adj_s4[i];
				neg_s5[i] <= adj_s4[i][AW-1] ^ det_s4[DW-1];
			end
		end
		if (en[3]) begin
			m_s6   <= m_s5;
			den_s6 <= den_s5;
			neg_s6 <= neg_s5;
			ovf_s6 <= ovf_c;
			inv_s6 <= inv_c;
			for (int i = 0; i < N; i++)
				num_s6[i] <= NW'({mag_s5[i], {(2*F){1'b0}}});
		end
	end

	assign out_valid = vld[3];
	assign m_out     = m_s6;
	assign num_out   = num_s6;
	assign den_out   = den_s6;
	assign neg_out   = neg_s6;
	assign ovf_out   = ovf_s6;
	assign inv_out   = inv_s6;

endmodule

// File: rtl/mi3_divider.sv
// Restoring divider pipeline: nine lanes, one quotient bit per stage, E stages.
module mi3_divider #(
	parameter int E  = mi3_pkg::ENTRY_WIDTH,
	parameter int NW = 2 * E + 1 + 2 * mi3_pkg::FRACTION_BITS,
	parameter int DW = 3 * E + 3
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [mi3_pkg::N_ENTRIES-1:0][E-1:0]   m_in,
	input  logic [mi3_pkg::N_ENTRIES-1:0][NW-1:0]  num_in,
	input  logic [DW-1:0]                          den_in,
	input  logic [mi3_pkg::N_ENTRIES-1:0]          neg_in,
	input  logic [mi3_pkg::N_ENTRIES-1:0]          ovf_in,
	input  logic                                   inv_in,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [mi3_pkg::N_ENTRIES-1:0][E-1:0]   m_out,
	output logic [mi3_pkg::N_ENTRIES-1:0][E-1:0]   quo_out,
	output logic [mi3_pkg::N_ENTRIES-1:0]          neg_out,
	output logic [mi3_pkg::N_ENTRIES-1:0]          ovf_out,
	output logic                                   inv_out
);

	localparam int N  = mi3_pkg::N_ENTRIES;
	localparam int XW = (NW > DW + E) ? NW : DW + E;

	logic [N-1:0][NW-1:0] rem_s [E];
	logic [N-1:0][E-1:0]  quo_s [E];
	logic [N-1:0][E-1:0]  m_s   [E];
	logic [DW-1:0]        den_s [E];
	logic [N-1:0]         neg_s [E];
	logic [N-1:0]         ovf_s [E];
	logic [E-1:0]         inv_s;
	logic [E-1:0]         vld_s;
	logic [E:0]           en;

	assign en[E]    = out_ready;
	assign in_ready = en[0];

	genvar j, l;
	generate
		for (j = 0; j < E; j++) begin : g_stage
			logic [N-1:0][NW-1:0] r_in;
			logic [N-1:0][E-1:0]  q_in;
			logic [N-1:0][E-1:0]  m_prv;
			logic [DW-1:0]        d_in;
			logic [N-1:0]         neg_prv, ovf_prv;
			logic                 inv_prv, v_prv;
			logic [N-1:0][NW-1:0] r_nx;
			logic [N-1:0]         ge;

			if (j == 0) begin : g_first
				assign r_in    = num_in;
				assign q_in    = '0;
				assign m_prv   = m_in;
				assign d_in    = den_in;
				assign neg_prv = neg_in;
				assign ovf_prv = ovf_in;
				assign inv_prv = inv_in;
				assign v_prv   = in_valid;
			end else begin : g_next
				assign r_in    = rem_s[j-1];
				assign q_in    = quo_s[j-1];
				assign m_prv   = m_s[j-1];
				assign d_in    = den_s[j-1];
				assign neg_prv = neg_s[j-1];
				assign ovf_prv = ovf_s[j-1];
				assign inv_prv = inv_s[j-1];
				assign v_prv   = vld_s[j-1];
			end

			assign en[j] = !vld_s[j] || en[j+1];

			// trial subtract of the divisor aligned to this stage's quotient bit
			for (l = 0; l < N; l++) begin : g_lane
				logic [XW-1:0] r_x, d_sh, diff;
				assign r_x     = XW'(r_in[l]);
				assign d_sh    = XW'(d_in) << (E - 1 - j);
				assign diff    = r_x - d_sh;
				assign ge[l]   = r_x >= d_sh;
				assign r_nx[l] = ge[l] ? diff[NW-1:0] : r_in[l];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[j] <= 1'b0;
				end else if (en[j]) begin
					vld_s[j] <= v_prv;
				end
			end

			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j] <= r_nx;
					for (int i = 0; i < N; i++)
						quo_s[j][i] <= {q_in[i][E-2:0], ge[i]};
					m_s[j]   <= m_prv;
					den_s[j] <= d_in;
					neg_s[j] <= neg_prv;
					ovf_s[j] <= ovf_prv;
					inv_s[j] <= inv_prv;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[E-1];
	assign m_out     = m_s[E-1];
	assign quo_out   = quo_s[E-1];
	assign neg_out   = neg_s[E-1];
	assign ovf_out   = ovf_s[E-1];
	assign inv_out   = inv_s[E-1];

endmodule

// File: rtl/matrix_inverse_3x3.sv
// Throughput: one matrix per cycle while out_ready does not hold the output;
// the divider retires one quotient bit per stage.
// Stalls hold each occupied stage; empty stages keep filling behind a stalled result.
// Reset (arst_n low, asynchronous) clears all valid bits and the threshold to zero.
// The threshold is sampled at the determinant check, so write it only while idle.
module matrix_inverse_3x3 #(
	parameter int ENTRY_WIDTH   = mi3_pkg::ENTRY_WIDTH,
	parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              singular_threshold_we,
	input  logic [mi3_pkg::THRESH_WIDTH-1:0]  singular_threshold,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ENTRY_WIDTH-1:0]     in_r1c1,
	input  logic signed [ENTRY_WIDTH-1:0]     in_r1c2,
	input  logic signed [ENTRY_WIDTH-1:0]     in_r1c3,
	input  logic signed [ENTRY_WIDTH-1:0]     in_r2c1,
	input  logic signed [ENTRY_WIDTH-1:0]     in_r2c2,
	input  logic signed [ENTRY_WIDTH-1:0]     in_r2c3,
	input  logic signed [ENTRY_WIDTH-1:0]     in_r3c1,
	input  logic signed [ENTRY_WIDTH-1:0]     in_r3c2,
	input  logic signed [ENTRY_WIDTH-1:0]     in_r3c3,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ENTRY_WIDTH-1:0]     out_r1c1,
	output logic signed [ENTRY_WIDTH-1:0]     out_r1c2,
	output logic signed [ENTRY_WIDTH-1:0]     out_r1c3,
	output logic signed [ENTRY_WIDTH-1:0]     out_r2c1,
	output logic signed [ENTRY_WIDTH-1:0]     out_r2c2,
	output logic signed [ENTRY_WIDTH-1:0]     out_r2c3,
	output logic signed [ENTRY_WIDTH-1:0]     out_r3c1,
	output logic signed [ENTRY_WIDTH-1:0]     out_r3c2,
	output logic signed [ENTRY_WIDTH-1:0]     out_r3c3,
	output logic                              invertible
);

	localparam int E  = ENTRY_WIDTH;
	localparam int N  = mi3_pkg::N_ENTRIES;
	localparam int NW = 2 * E + 1 + 2 * FRACTION_BITS;
	localparam int DW = 3 * E + 3;

	logic [mi3_pkg::THRESH_WIDTH-1:0] thr_q;
	logic [N-1:0][E-1:0]  m_in;
	logic                 cof_ready, cof_valid, det_ready, det_valid;
	logic                 div_valid, div_ready, div_ready_up;
	logic [N-1:0][E-1:0]  cof_m, det_m, div_m, div_quo;
	logic [N-1:0][2*E:0]  cof_adj;
	logic [N-1:0][NW-1:0] det_num;
	logic [DW-1:0]        det_den;
	logic [N-1:0]         det_neg, det_ovf, div_neg, div_ovf;
	logic                 det_inv, div_inv;
	logic [N-1:0][E-1:0]  res_ent_q;
	logic [N-1:0][E-1:0]  res_c;
	logic                 res_inv_q, res_valid_q;
	logic [E-1:0]         lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (singular_threshold_we) begin
			thr_q <= singular_threshold;
		end
	end

	assign m_in[0] = in_r1c1;
	assign m_in[1] = in_r1c2;
	assign m_in[2] = in_r1c3;
	assign m_in[3] = in_r2c1;
	assign m_in[4] = in_r2c2;
	assign m_in[5] = in_r2c3;
	assign m_in[6] = in_r3c1;
	assign m_in[7] = in_r3c2;
	assign m_in[8] = in_r3c3;

	assign in_ready = cof_ready;

	mi3_cofactor #(.E(E)) u_cof (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (cof_ready),
		.m_in      (m_in),
		.out_valid (cof_valid),
		.out_ready (det_ready),
		.m_out     (cof_m),
		.adj_out   (cof_adj)
	);

	mi3_det #(.E(E), .F(FRACTION_BITS), .NW(NW), .DW(DW)) u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.thr       (thr_q),
		.in_valid  (cof_valid),
		.in_ready  (det_ready),
		.m_in      (cof_m),
		.adj_in    (cof_adj),
		.out_valid (det_valid),
		.out_ready (div_ready_up),
		.m_out     (det_m),
		.num_out   (det_num),
		.den_out   (det_den),
		.neg_out   (det_neg),
		.ovf_out   (det_ovf),
		.inv_out   (det_inv)
	);

	mi3_divider #(.E(E), .NW(NW), .DW(DW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (det_valid),
		.in_ready  (div_ready_up),
		.m_in      (det_m),
		.num_in    (det_num),
		.den_in    (det_den),
		.neg_in    (det_neg),
		.ovf_in    (det_ovf),
		.inv_in    (det_inv),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.m_out     (div_m),
		.quo_out   (div_quo),
		.neg_out   (div_neg),
		.ovf_out   (div_ovf),
		.inv_out   (div_inv)
	);

	assign div_ready = !res_valid_q || out_ready;
	assign lim       = {1'b1, {(E-1){1'b0}}};

	// saturate the signed quotient; pass the input through when singular
	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (!div_inv)
				res_c[i] = div_m[i];
			else if (div_neg[i])
				res_c[i] = (div_ovf[i] || div_quo[i] > lim) ? lim : (E'(0) - div_quo[i]);
			else
				res_c[i] = (div_ovf[i] || div_quo[i][E-1]) ? ~lim : div_quo[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (div_ready) begin
			res_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ready) begin
			res_ent_q <= res_c;
			res_inv_q <= div_inv;
		end
	end

	assign out_valid  = res_valid_q;
	assign invertible = res_inv_q;
	assign out_r1c1   = res_ent_q[0];
	assign out_r1c2   = res_ent_q[1];
	assign out_r1c3   = res_ent_q[2];
	assign out_r2c1   = res_ent_q[3];
	assign out_r2c2   = res_ent_q[4];
	assign out_r2c3   = res_ent_q[5];
	assign out_r3c1   = res_ent_q[6];
	assign out_r3c2   = res_ent_q[7];
	assign out_r3c3   = res_ent_q[8];

endmodule

// File: tb/sv/matrix_inverse_3x3_tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverter.
`timescale 1ns / 1ps

module matrix_inverse_3x3_tb;

	typedef logic [mi3_pkg::N_ENTRIES-1:0][mi3_pkg::ENTRY_WIDTH-1:0] mat_t;
	typedef struct packed {
		mat_t v;
		logic inv;
	} inv_result_t;
	typedef struct packed {
		logic [mi3_pkg::THRESH_WIDTH-1:0] thr;
		mat_t                             m;
		logic                             has_exp;
		inv_result_t                      ex;
	} dir_row_t;

	localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
	localparam logic signed [127:0] Q_MIN = -128'sd2147483648;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic singular_threshold_we = 1'b0;
	logic [mi3_pkg::THRESH_WIDTH-1:0] singular_threshold = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	mat_t drv_m = '0;
	logic drv_has_exp = 1'b0;
	inv_result_t drv_exp = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	mat_t out_m;
	logic invertible;

	logic [mi3_pkg::THRESH_WIDTH-1:0] cur_thr = '0;
	inv_result_t inverse_q [$];
	int errors = 0;
	int hold_cnt = 0;
	bit quiet = 0;
	int idle_cycles = 0;
	dir_row_t dir_rows [$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	matrix_inverse_3x3 u_top (
		.clk(clk), .arst_n(arst_n),
		.singular_threshold_we(singular_threshold_we),
		.singular_threshold(singular_threshold),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_r1c1(drv_m[0]), .in_r1c2(drv_m[1]), .in_r1c3(drv_m[2]),
		.in_r2c1(drv_m[3]), .in_r2c2(drv_m[4]), .in_r2c3(drv_m[5]),
		.in_r3c1(drv_m[6]), .in_r3c2(drv_m[7]), .in_r3c3(drv_m[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_r1c1(out_m[0]), .out_r1c2(out_m[1]), .out_r1c3(out_m[2]),
		.out_r2c1(out_m[3]), .out_r2c2(out_m[4]), .out_r2c3(out_m[5]),
		.out_r3c1(out_m[6]), .out_r3c2(out_m[7]), .out_r3c3(out_m[8]),
		.invertible(invertible)
	);

	// Exact adjugate over determinant, truncated toward zero and saturated.
	function automatic inv_result_t invert_predict(mat_t m,
			logic [mi3_pkg::THRESH_WIDTH-1:0] thr);
		logic signed [127:0] e [9];
		logic signed [127:0] adj [9];
		logic signed [127:0] det, mag, thr_w, q;
		inv_result_t r;
		for (int i = 0; i < 9; i++)
			e[i] = $signed(m[i]);
		for (int i = 0; i < 9; i++)
			adj[i] = e[mi3_pkg::COF_IDX[i][0]] * e[mi3_pkg::COF_IDX[i][1]]
				- e[mi3_pkg::COF_IDX[i][2]] * e[mi3_pkg::COF_IDX[i][3]];
		det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
		mag = (det < 0) ? -det : det;
		thr_w = $signed({97'b0, thr}) <<< (2 * mi3_pkg::FRACTION_BITS);
		if (mag > thr_w) begin
			for (int i = 0; i < 9; i++) begin
				q = (adj[i] <<< (2 * mi3_pkg::FRACTION_BITS)) / det;
				if (q > Q_MAX) q = Q_MAX;
				if (q < Q_MIN) q = Q_MIN;
				r.v[i] = q[31:0];
			end
			r.inv = 1'b1;
		end else begin
			r.v = m;
			r.inv = 1'b0;
		end
		return r;
	endfunction

	function automatic mat_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		mat_t m = '0;
		m[0] = a;
		m[4] = b;
		m[8] = c;
		return m;
	endfunction

	function automatic mat_t fill(logic [31:0] a);
		mat_t m;
		for (int i = 0; i < 9; i++)
			m[i] = a;
		return m;
	endfunction

	function automatic dir_row_t row(logic [mi3_pkg::THRESH_WIDTH-1:0] thr, mat_t m,
			logic has_exp, mat_t ev, logic einv);
		dir_row_t d;
		d.thr = thr;
		d.m = m;
		d.has_exp = has_exp;
		d.ex.v = ev;
		d.ex.inv = einv;
		return d;
	endfunction

	function automatic logic [31:0] small_val();
		return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
	endfunction

	function automatic mat_t rand_matrix();
		mat_t m;
		int mode;
		int src;
		logic [31:0] picks [5];
		picks = '{32'h0, ONE, -ONE, 32'h7FFF_FFFF, 32'h8000_0000};
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++)
			m[i] = small_val();
		case (mode)
			0, 1: begin
				for (int i = 0; i < 9; i++)
					m[i] = $urandom;
			end
			6: begin
				m = diag(small_val(), small_val(), small_val());
			end
			7: begin
				// copy one row over another so the determinant is exactly zero
				src = $urandom_range(0, 2);
				for (int c = 0; c < 3; c++)
					m[((src + 1) % 3) * 3 + c] = m[src * 3 + c];
			end
			8: begin
				for (int i = 0; i < 9; i++)
					if ($urandom_range(0, 1)) m[i] = 32'h0;
			end
			9: begin
				for (int i = 0; i < 9; i++)
					m[i] = picks[$urandom_range(0, 4)];
			end
			default: ;
		endcase
		return m;
	endfunction

	task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s[%0d] got %h want %h at %0t", what, idx, got, want, $realtime);
		errors++;
	endtask

	// Scoreboard and watchdog
	always @(posedge clk) begin
		inv_result_t ex;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", idle_cycles);
				$display("status: fail");
				$finish;
			end
			if (in_valid && in_ready)
				inverse_q.push_back(drv_has_exp ? drv_exp : invert_predict(drv_m, cur_thr));
			if (out_valid && out_ready) begin
				if (inverse_q.size() == 0) begin
					report("unexpected", 0, out_m[0], 32'h0);
				end else begin
					ex = inverse_q.pop_front();
					for (int i = 0; i < 9; i++)
						if (out_m[i] !== ex.v[i]) report("entry", i, out_m[i], ex.v[i]);
					if (invertible !== ex.inv) report("invertible", 0, invertible, ex.inv);
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				out_ready <= 1'b0;
				hold_cnt--;
			end else begin
				out_ready <= quiet || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	task automatic send_matrix(mat_t m, logic has_exp, inv_result_t ex);
		int gap;
		if (!quiet && $urandom_range(0, 99) < 4) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		drv_m <= m;
		drv_has_exp <= has_exp;
		drv_exp <= ex;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (inverse_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_threshold(logic [mi3_pkg::THRESH_WIDTH-1:0] v);
		drain();
		singular_threshold_we <= 1'b1;
		singular_threshold <= v;
		@(posedge clk);
		singular_threshold_we <= 1'b0;
		cur_thr = v;
	endtask

	initial begin
		logic [mi3_pkg::THRESH_WIDTH-1:0] phase_thr [6];
		mat_t m;
		phase_thr = '{31'd0, 31'd1, 31'h7FFF_FFFF, 31'd65536, 31'd0, 31'd0};
		phase_thr[4] = $urandom;
		phase_thr[5] = $urandom_range(0, 4096);

		dir_rows.push_back(row(0, diag(ONE, ONE, ONE), 1, diag(ONE, ONE, ONE), 1));
		dir_rows.push_back(row(0, '0, 1, '0, 0));
		dir_rows.push_back(row(0, diag(1, 1, 1), 1,
			diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1));
		dir_rows.push_back(row(0, diag(-1, -1, -1), 1,
			diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1));
		dir_rows.push_back(row(0, fill(32'h7FFF_FFFF), 1, fill(32'h7FFF_FFFF), 0));
		dir_rows.push_back(row(0, fill(32'h8000_0000), 1, fill(32'h8000_0000), 0));
		m = {ONE * 6, ONE * 5, ONE * 4, ONE * 3, ONE * 2, ONE, ONE * 3, ONE * 2, ONE};
		dir_rows.push_back(row(0, m, 1, m, 0));
		dir_rows.push_back(row(0, diag(2 * ONE, -2 * ONE, ONE / 2), 0, '0, 0));
		m = {32'h0, ONE * 6, ONE * 5, ONE * 4, ONE, 32'h0, ONE * 3, ONE * 2, ONE};
		dir_rows.push_back(row(0, m, 0, '0, 0));
		dir_rows.push_back(row(0, diag(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0, '0, 0));
		m = {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h1234_5678, 32'hAAAA_AAAA, 32'hFEDC_BA98, 32'h0F0F_0F0F};
		dir_rows.push_back(row(0, m, 0, '0, 0));
		dir_rows.push_back(row(0, ~m, 0, '0, 0));
		dir_rows.push_back(row(65536, diag(ONE, ONE, ONE), 1, diag(ONE, ONE, ONE), 0));
		dir_rows.push_back(row(65535, diag(ONE, ONE, ONE), 1, diag(ONE, ONE, ONE), 1));
		dir_rows.push_back(row(31'h7FFF_FFFF, diag(ONE, ONE, ONE), 1, diag(ONE, ONE, ONE), 0));
		dir_rows.push_back(row(31'h7FFF_FFFF,
			diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, '0, 0));
		dir_rows.push_back(row(31'h7FFF_FFFF, fill(32'h8000_0000), 1, fill(32'h8000_0000), 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].thr != cur_thr) write_threshold(dir_rows[i].thr);
			send_matrix(dir_rows[i].m, dir_rows[i].has_exp, dir_rows[i].ex);
		end

		for (int p = 0; p < 6; p++) begin
			write_threshold(phase_thr[p]);
			quiet = (p == 2);
			// long receiver hold so the pipeline fills and backs up the input
			if (p == 1) hold_cnt = 400;
			for (int n = 0; n < 90; n++)
				send_matrix(rand_matrix(), 0, '0);
		end
		quiet = 0;

		drain();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
